// File: rtl/core/codel_pkg.sv
`default_nettype none

package codel_pkg;

    // Field widths
    localparam int TimeW    = 64;
    localparam int BytesW   = 16;
    localparam int BacklogW = 32;
    localparam int CountW   = 32;
    localparam int CfgW     = 16;
    localparam int CfgIdxW  = 2;
    localparam int VerdictW = 2;
    localparam int RootW    = 16;
    localparam int SInW     = 176;
    localparam int MOutW    = 40;

    // Register reset values
    localparam logic [CfgW-1:0] TargetReset   = 16'd5;
    localparam logic [CfgW-1:0] IntervalReset = 16'd100;
    localparam logic [CfgW-1:0] MaxPktReset   = 16'd1500;

    // Register indexes
    localparam logic [CfgIdxW-1:0] RegTarget   = 2'd0;
    localparam logic [CfgIdxW-1:0] RegInterval = 2'd1;
    localparam logic [CfgIdxW-1:0] RegMaxPkt   = 2'd2;

    // Verdict codes
    localparam logic [VerdictW-1:0] VerdictEmpty   = 2'd0;
    localparam logic [VerdictW-1:0] VerdictDeliver = 2'd1;
    localparam logic [VerdictW-1:0] VerdictDrop    = 2'd2;

    // Follow-up modes
    localparam logic [1:0] ModeNone    = 2'd0;
    localparam logic [1:0] ModeDrop    = 2'd1;
    localparam logic [1:0] ModeEntered = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic eval;
        logic div_step;
        logic sqrt_init;
        logic sqrt_step;
        logic law_add;
        logic out_load;
    } codel_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic need_law;
    } codel_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/codel_ctrl.sv
`default_nettype none

module codel_ctrl (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    input  codel_pkg::codel_stat_t    stat,
    output codel_pkg::codel_cmd_t     cmd
);
    import codel_pkg::*;

    localparam logic [2:0] StIdle  = 3'd0;
    localparam logic [2:0] StEval  = 3'd1;
    localparam logic [2:0] StDiv   = 3'd2;
    localparam logic [2:0] StSqi   = 3'd3;
    localparam logic [2:0] StSqrt  = 3'd4;
    localparam logic [2:0] StAdd   = 3'd5;
    localparam logic [2:0] StOut   = 3'd6;

    localparam logic [4:0] DivLast  = 5'd31;
    localparam logic [4:0] SqrtLast = 5'd15;

    logic [2:0] state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       mvalid_reg, mvalid_next;
    logic       out_free;

    assign s_tready = (state_reg == StIdle);
    assign m_tvalid = mvalid_reg;
    assign out_free = !mvalid_reg || m_tready;

    // Sequence one item: evaluate, then optional divide and root, then emit
    always_comb begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        mvalid_next = mvalid_reg && !m_tready;
        cmd         = '0;
        unique case (state_reg)
            StIdle: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = StEval;
                end
            end
            StEval: begin
                cmd.eval   = 1'b1;
                cnt_next   = '0;
                state_next = stat.need_law ? StDiv : StOut;
            end
            StDiv: begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == DivLast) state_next = StSqi;
            end
            StSqi: begin
                cmd.sqrt_init = 1'b1;
                cnt_next      = '0;
                state_next    = StSqrt;
            end
            StSqrt: begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 5'd1;
                if (cnt_reg == SqrtLast) state_next = StAdd;
            end
            StAdd: begin
                cmd.law_add = 1'b1;
                state_next  = StOut;
            end
            StOut: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = StIdle;
                end
            end
            default: state_next = StIdle;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= StIdle;
            cnt_reg    <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            cnt_reg    <= cnt_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/codel_dp.sv
`default_nettype none

module codel_dp (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      cfg_valid,
    input  wire logic [codel_pkg::CfgIdxW-1:0] cfg_index,
    input  wire logic [codel_pkg::CfgW-1:0]    cfg_data,
    input  wire logic [codel_pkg::SInW-1:0]    s_tdata,
    output logic [codel_pkg::MOutW-1:0]        m_tdata,
    input  codel_pkg::codel_cmd_t          cmd,
    output codel_pkg::codel_stat_t         stat
);
    import codel_pkg::*;

    // Configuration
    logic [CfgW-1:0] target_reg, interval_reg, maxpkt_reg;

    // Captured item
    logic [TimeW-1:0]    now_reg, arr_reg;
    logic [BytesW-1:0]   pkt_reg;
    logic [BacklogW-1:0] backlog_reg;

    // Decision state
    logic [TimeW-1:0]  ad_reg, ndt_reg, base_reg;
    logic [CountW-1:0] cnt_reg;
    logic              drop_reg;
    logic [1:0]        mode_reg;
    logic [VerdictW-1:0] verdict_reg;

    // Divider and root
    logic [CountW-1:0] rem_reg, quo_reg, dsr_reg;
    logic [31:0]       sv_reg, sr_reg, sbit_reg;
    logic [MOutW-1:0]  out_reg;

    // Evaluation results
    logic [TimeW-1:0]    soj, ad_next;
    logic                ok, recent, far, size0;
    logic [VerdictW-1:0] verdict_next;
    logic                dflag_next, need_law;
    logic [CountW-1:0]   cnt_next;
    logic [1:0]          mode_next;
    logic [TimeW-1:0]    base_next;

    always_comb begin
        size0 = (pkt_reg == '0);
        soj   = now_reg - arr_reg;
        if (size0 || soj < {48'd0, target_reg} || backlog_reg < {16'd0, maxpkt_reg}) begin
            ad_next = '0;
            ok      = 1'b0;
        end else if (ad_reg == '0) begin
            ad_next = now_reg + {48'd0, interval_reg};
            ok      = 1'b0;
        end else begin
            ad_next = ad_reg;
            ok      = (now_reg >= ad_reg);
        end
        recent = ((now_reg - ndt_reg) < {48'd0, interval_reg});
        far    = ((now_reg - ad_reg) >= {48'd0, interval_reg});

        verdict_next = VerdictDeliver;
        dflag_next   = drop_reg;
        cnt_next     = cnt_reg;
        mode_next    = ModeNone;
        need_law     = 1'b0;
        base_next    = ndt_reg;
        if (mode_reg != ModeNone) begin
            // Follow-up after a drop: sojourn check only
            if (mode_reg == ModeDrop) begin
                if (!ok) dflag_next = 1'b0;
                else     need_law   = 1'b1;
            end
            verdict_next = size0 ? VerdictEmpty : VerdictDeliver;
        end else if (size0) begin
            dflag_next   = 1'b0;
            verdict_next = VerdictEmpty;
        end else if (drop_reg) begin
            if (!ok) begin
                dflag_next = 1'b0;
            end else if (now_reg >= ndt_reg) begin
                verdict_next = VerdictDrop;
                if (cnt_reg != '1) cnt_next = cnt_reg + 32'd1;
                mode_next = ModeDrop;
            end
        end else if (ok && (recent || far)) begin
            // Enter dropping state
            verdict_next = VerdictDrop;
            dflag_next   = 1'b1;
            if (recent) cnt_next = (cnt_reg > 32'd2) ? cnt_reg - 32'd2 : 32'd1;
            else        cnt_next = 32'd1;
            need_law  = 1'b1;
            base_next = now_reg;
            mode_next = ModeEntered;
        end
    end

    assign stat.need_law = need_law;

    // Divider step
    logic [CountW:0]   dshift;
    logic              dge;
    assign dshift = {rem_reg, quo_reg[CountW-1]};
    assign dge    = (dshift >= {1'b0, dsr_reg});

    // Root step
    logic [31:0] strial;
    logic        sge;
    assign strial = sr_reg + sbit_reg;
    assign sge    = (sv_reg >= strial);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg   <= TargetReset;
            interval_reg <= IntervalReset;
            maxpkt_reg   <= MaxPktReset;
            ad_reg       <= '0;
            ndt_reg      <= '0;
            cnt_reg      <= '0;
            drop_reg     <= 1'b0;
            mode_reg     <= ModeNone;
        end else begin
            // Register writes
            if (cfg_valid) begin
                unique case (cfg_index)
                    RegTarget:   target_reg   <= cfg_data;
                    RegInterval: interval_reg <= cfg_data;
                    RegMaxPkt:   maxpkt_reg   <= cfg_data;
                    default: ;
                endcase
            end
            // Commit decision state
            if (cmd.eval) begin
                ad_reg   <= ad_next;
                cnt_reg  <= cnt_next;
                drop_reg <= dflag_next;
                mode_reg <= mode_next;
            end
            if (cmd.law_add) ndt_reg <= base_reg + {48'd0, sr_reg[RootW-1:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            now_reg     <= s_tdata[63:0];
            arr_reg     <= s_tdata[127:64];
            pkt_reg     <= s_tdata[143:128];
            backlog_reg <= s_tdata[175:144];
        end
        // Load divider with interval squared over count
        if (cmd.eval) begin
            verdict_reg <= verdict_next;
            base_reg    <= base_next;
            rem_reg     <= '0;
            quo_reg     <= {16'd0, interval_reg} * {16'd0, interval_reg};
            dsr_reg     <= (cnt_next == '0) ? 32'd1 : cnt_next;
        end
        if (cmd.div_step) begin
            rem_reg <= dge ? dshift[CountW-1:0] - dsr_reg : dshift[CountW-1:0];
            quo_reg <= {quo_reg[CountW-2:0], dge};
        end
        if (cmd.sqrt_init) begin
            sv_reg   <= quo_reg;
            sr_reg   <= '0;
            sbit_reg <= 32'h4000_0000;
        end
        if (cmd.sqrt_step) begin
            if (sge) begin
                sv_reg <= sv_reg - strial;
                sr_reg <= (sr_reg >> 1) + sbit_reg;
            end else begin
                sr_reg <= sr_reg >> 1;
            end
            sbit_reg <= sbit_reg >> 2;
        end
        if (cmd.out_load) out_reg <= {5'd0, cnt_reg, drop_reg, verdict_reg};
    end

    assign m_tdata = out_reg;

endmodule

`default_nettype wire

// File: rtl/core/codel_dequeue_drop_decision.sv
`default_nettype none

// CoDel drop decision at a queue head. One s_ transaction per head-of-queue
// packet (packet_bytes zero marks an empty queue) yields one m_ transaction
// with the verdict (0 empty, 1 deliver, 2 drop), the dropping flag and the
// drop count. Items are handled one at a time. The control law runs when
// entering dropping state, or for a follow-up item after a drop while
// dropping, and uses a 32-step restoring divider and a 16-step square root.
// The next item can be accepted in the cycle after the result is loaded. A
// waiting result does not block acceptance of the next item. Registers are
// written on the cfg_ port (0 target_delay, 1 interval_time,
// 2 max_packet_bytes); the user must write them only while idle, as the
// block itself does not enforce it.
module codel_dequeue_drop_decision (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // now_time[63:0], arrival_time[127:64], packet_bytes[143:128],
    // backlog_bytes[175:144]
    input  wire logic [codel_pkg::SInW-1:0]        s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // verdict[1:0], in_dropping[2], drop_count_now[34:3], zero fill
    output logic [codel_pkg::MOutW-1:0]            m_tdata,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [codel_pkg::CfgIdxW-1:0]     cfg_index,
    input  wire logic [codel_pkg::CfgW-1:0]        cfg_data
);
    import codel_pkg::*;

    codel_cmd_t  cmd;
    codel_stat_t stat;

    assign cfg_ready = 1'b1;

    codel_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    codel_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .stat      (stat)
    );

endmodule

`default_nettype wire

// File: rtl/core/codel_chk.sv
`default_nettype none

module codel_chk (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_tvalid,
    input wire logic                            m_tready,
    input wire logic [codel_pkg::MOutW-1:0]     m_tdata
);
    import codel_pkg::*;

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Only defined verdicts
    a_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[1:0] == VerdictEmpty || m_tdata[1:0] == VerdictDeliver
                      || m_tdata[1:0] == VerdictDrop))
        else $error("undefined verdict");

    // A drop leaves the block in dropping state
    a_dropflag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == VerdictDrop |-> m_tdata[2])
        else $error("drop outside dropping state");

    // A drop always carries a nonzero count
    a_dropcnt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1:0] == VerdictDrop |-> m_tdata[34:3] != '0)
        else $error("drop with zero count");

endmodule

bind codel_dequeue_drop_decision codel_chk u_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
